// ----- hdl/bpa_pkg.sv -----
// Package with shared constants, codes and types of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
	localparam int unsigned PAGES_DEF = 65536;
	localparam int unsigned MAP_WORD_BITS_DEF = 64;
	localparam int unsigned CNT_W = 17;
	localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NO_RUN = 2'd1,
		ST_ZERO   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN,
		S_MARK_RD,
		S_MARK,
		S_RANGE_RD,
		S_RANGE,
		S_REPLY
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/bitmap_page_allocator.sv -----
// Top level of the bitmap first-fit page allocator with its map memory and sequencer.
//
// Channel    Direction  Signals
// request    in         start, op, first_page, page_count (taken when start && !busy)
// result     out        done, status, run_start, pages_changed, free_pages
// config     in         managed_pages_we, managed_pages_wdata
//
// After reset a clearing pass writes all ones into every map word, one word a cycle, with
// busy high. A request then reads each map word it visits and tests or updates each page
// it covers in turn, through one shared bit unit: an allocate scans from page zero to the
// end of the first free run long enough and then marks that run; free and reserve walk
// their range one page a cycle, apart from the read of each map word.
// The result shows on done for one cycle after the work ends; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator #(
	parameter int unsigned PAGES = bpa_pkg::PAGES_DEF,
	parameter int unsigned MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] first_page,
	input  wire logic [16:0] page_count,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      run_start,
	output logic [16:0]      pages_changed,
	output logic [16:0]      free_pages,
	input  wire logic        managed_pages_we,
	input  wire logic [16:0] managed_pages_wdata
);
	localparam int unsigned WORDS = (PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BW = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
	localparam int unsigned CW = bpa_pkg::CNT_W;
	localparam int unsigned PW_PAGE = $clog2(PAGES + 1) + 1;
	localparam int unsigned PW = (PW_PAGE > CW + 1) ? PW_PAGE : CW + 1;

	// Map memory, one port, registered read.
	logic [MAP_WORD_BITS-1:0] mem [WORDS];
	logic [MAP_WORD_BITS-1:0] rdata_q, wdata;
	logic [AW-1:0]            addr;
	logic                     we;
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	bpa_pkg::state_t state_q, state_d;
	logic [CW-1:0] managed_q, free_q, changed_q, count_q;
	logic [PW-1:0] page_q, end_q, run_at_q, run_q, lim;
	logic [MAP_WORD_BITS-1:0] word_q, word_cur;
	logic [1:0] op_q, status_q;
	logic [AW-1:0] clr_q;
	logic fresh_q;

	// Limit of managed pages.
	always_comb begin
		if (32'(managed_q) > PAGES) begin
			lim = PW'(PAGES);
		end else begin
			lim = PW'(managed_q);
		end
	end

	// Current page bit within the held word; a word just read comes from the memory.
	logic [BW-1:0] bit_idx;
	logic [AW-1:0] word_idx;
	logic cur_bit, last_in_word, at_end, want;
	assign word_cur = fresh_q ? rdata_q : word_q;
	assign bit_idx = page_q[BW-1:0];
	assign word_idx = AW'(page_q >> BW);
	assign cur_bit = word_cur[bit_idx];
	assign last_in_word = (bit_idx == BW'(MAP_WORD_BITS - 1));
	assign want = (op_q == 2'(bpa_pkg::OP_RESERVE));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::S_IDLE: begin
				if (start) begin
					state_d = bpa_pkg::S_REPLY;
					if (op == 2'(bpa_pkg::OP_ALLOC)) begin
						if (page_count != '0) begin
							state_d = bpa_pkg::S_SCAN_RD;
						end
					end else if (op != 2'(bpa_pkg::OP_NONE)) begin
						state_d = bpa_pkg::S_RANGE_RD;
					end
				end
			end
			bpa_pkg::S_CLEAR: begin
				if (clr_q == AW'(WORDS - 1)) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_SCAN_RD: begin
				state_d = (page_q >= lim) ? bpa_pkg::S_REPLY : bpa_pkg::S_SCAN;
			end
			bpa_pkg::S_SCAN: begin
				if (!cur_bit && (run_q + 1'b1 >= PW'(count_q))) begin
					state_d = bpa_pkg::S_MARK_RD;
				end else if (page_q + 1'b1 >= lim) begin
					state_d = bpa_pkg::S_REPLY;
				end else if (last_in_word) begin
					state_d = bpa_pkg::S_SCAN_RD;
				end
			end
			bpa_pkg::S_MARK_RD: state_d = bpa_pkg::S_MARK;
			bpa_pkg::S_MARK: begin
				if (page_q + 1'b1 >= end_q) begin
					state_d = bpa_pkg::S_REPLY;
				end else if (last_in_word) begin
					state_d = bpa_pkg::S_MARK_RD;
				end
			end
			bpa_pkg::S_RANGE_RD: begin
				state_d = (page_q >= end_q) ? bpa_pkg::S_REPLY : bpa_pkg::S_RANGE;
			end
			bpa_pkg::S_RANGE: begin
				if (page_q + 1'b1 >= end_q) begin
					state_d = bpa_pkg::S_REPLY;
				end else if (last_in_word) begin
					state_d = bpa_pkg::S_RANGE_RD;
				end
			end
			bpa_pkg::S_REPLY: state_d = bpa_pkg::S_IDLE;
			default: state_d = bpa_pkg::S_IDLE;
		endcase
	end

	// Memory port and outputs.
	assign at_end = 1'b0;
	always_comb begin
		we = 1'b0;
		addr = word_idx;
		wdata = word_cur;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				we = 1'b1;
				addr = clr_q;
				wdata = '1;
			end
			bpa_pkg::S_MARK: begin
				wdata[bit_idx] = 1'b1;
				we = (page_q + 1'b1 >= end_q) || last_in_word;
			end
			bpa_pkg::S_RANGE: begin
				wdata[bit_idx] = want;
				we = (page_q + 1'b1 >= end_q) || last_in_word;
			end
			default: ;
		endcase
		busy = (state_q != bpa_pkg::S_IDLE) || at_end;
		done = (state_q == bpa_pkg::S_REPLY);
		status = status_q;
		run_start = (status_q == 2'(bpa_pkg::ST_DONE)) ? 16'(run_at_q) : 16'd0;
		pages_changed = changed_q;
		free_pages = free_q;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
			clr_q <= '0;
			managed_q <= 17'd65536;
			free_q <= '0;
		end else begin
			state_q <= state_d;
			if (managed_pages_we) begin
				managed_q <= managed_pages_wdata;
			end
			case (state_q)
				bpa_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				bpa_pkg::S_MARK: begin
					if (free_q != '0) free_q <= free_q - 1'b1;
				end
				bpa_pkg::S_RANGE: begin
					if (cur_bit != want) begin
						if (want) begin
							if (free_q != '0) free_q <= free_q - 1'b1;
						end else if (free_q != bpa_pkg::COUNT_MAX) begin
							free_q <= free_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Request payload and working registers.
	always_ff @(posedge clk) begin
		fresh_q <= state_q inside {bpa_pkg::S_SCAN_RD, bpa_pkg::S_MARK_RD,
			bpa_pkg::S_RANGE_RD};
		case (state_q)
			bpa_pkg::S_IDLE: begin
				op_q <= op;
				count_q <= page_count;
				changed_q <= '0;
				run_q <= '0;
				run_at_q <= '0;
				status_q <= 2'(bpa_pkg::ST_DONE);
				if (op == 2'(bpa_pkg::OP_ALLOC)) begin
					page_q <= '0;
					if (page_count == '0) status_q <= 2'(bpa_pkg::ST_ZERO);
				end else begin
					page_q <= PW'(first_page);
					if (PW'(first_page) + PW'(page_count) > lim) begin
						end_q <= lim;
					end else begin
						end_q <= PW'(first_page) + PW'(page_count);
					end
				end
			end
			bpa_pkg::S_SCAN_RD, bpa_pkg::S_MARK_RD, bpa_pkg::S_RANGE_RD: begin
				if (state_q == bpa_pkg::S_SCAN_RD && page_q >= lim) begin
					status_q <= 2'(bpa_pkg::ST_NO_RUN);
				end
			end
			bpa_pkg::S_SCAN: begin
				word_q <= word_cur;
				if (!cur_bit) begin
					if (run_q == '0) run_at_q <= page_q;
					run_q <= run_q + 1'b1;
					if (run_q + 1'b1 >= PW'(count_q)) begin
						page_q <= (run_q == '0) ? page_q : run_at_q;
						end_q <= ((run_q == '0) ? page_q : run_at_q) + PW'(count_q);
						changed_q <= count_q;
					end else begin
						page_q <= page_q + 1'b1;
					end
				end else begin
					run_q <= '0;
					page_q <= page_q + 1'b1;
				end
				if ((cur_bit || run_q + 1'b1 < PW'(count_q)) && page_q + 1'b1 >= lim) begin
					status_q <= 2'(bpa_pkg::ST_NO_RUN);
				end
			end
			bpa_pkg::S_MARK: begin
				word_q <= wdata;
				page_q <= page_q + 1'b1;
			end
			bpa_pkg::S_RANGE: begin
				word_q <= wdata;
				page_q <= page_q + 1'b1;
				if (cur_bit != want) changed_q <= changed_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
